// File: src/i2cm_pkg.sv
package i2cm_pkg;

  // Reset value of the half period register, in clock ticks.
  localparam logic [15:0] HALF_PERIOD_RESET = 16'd500;

  // Default width of the half period counter.
  localparam int WAIT_WIDTH_DEFAULT = 16;

  // Depth of the queues between the channels and the engine.
  localparam int QUEUE_DEPTH = 2;

  // Bit positions within one byte transfer: eight data bits, then the ACK bit.
  localparam logic [3:0] BIT_ACK  = 4'd8;
  localparam logic [3:0] BIT_LAST = 4'd9;

  // Command codes as they arrive on the input channel.
  typedef enum logic [2:0] {
    CMD_NONE  = 3'd0,
    CMD_START = 3'd1,
    CMD_STOP  = 3'd2,
    CMD_WRITE = 3'd3,
    CMD_READ  = 3'd4
  } cmd_e;

  // Command class after decoding; unknown codes become no command.
  typedef enum logic [2:0] {
    KIND_NONE,
    KIND_START,
    KIND_STOP,
    KIND_WRITE,
    KIND_READ
  } kind_e;

  typedef struct packed {
    logic [2:0] cmd;
    logic [7:0] write_data;
    logic       send_ack;
    logic       scl_level;
    logic       sda_level;
  } in_item_t;

  typedef struct packed {
    logic       scl_pull_low;
    logic       sda_pull_low;
    logic       busy_res;
    logic       done_res;
    logic [7:0] read_data;
    logic       ack_received;
  } res_item_t;

  // Decoded item handed from the front end to the engine.
  typedef struct packed {
    kind_e      kind;
    logic [7:0] write_data;
    logic       send_ack;
    logic       scl_level;
    logic       sda_level;
  } fe_item_t;

endpackage

// File: src/i2cm_fifo.sv
module i2cm_fifo
  import i2cm_pkg::*;
#(
  parameter int Width = 8,
  parameter int Depth = QUEUE_DEPTH
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             wr_valid_i,
  input  logic [Width-1:0] wr_data_i,
  output logic             full_o,
  input  logic             rd_ready_i,
  output logic [Width-1:0] rd_data_o,
  output logic             empty_o
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  count_q, count_d;
  logic             do_wr, do_rd;

  assign full_o    = (count_q == CntW'(Depth));
  assign empty_o   = (count_q == '0);
  assign do_wr     = wr_valid_i && !full_o;
  assign do_rd     = rd_ready_i && !empty_o;
  assign rd_data_o = mem_q[rd_ptr_q];

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_wr) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_rd) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_wr && !do_rd) begin
      count_d = count_q + 1'b1;
    end else if (do_rd && !do_wr) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Storage needs no reset.
  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

endmodule

// File: src/i2cm_front.sv
module i2cm_front
  import i2cm_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_i,
  input  in_item_t item_i,
  output logic     full_o,
  input  logic     pop_i,
  output fe_item_t item_o,
  output logic     empty_o
);

  fe_item_t                 dec;
  logic [$bits(fe_item_t)-1:0] rd_bits;

  // Classify the command code; codes outside the list carry no command.
  always_comb begin
    dec.write_data = item_i.write_data;
    dec.send_ack   = item_i.send_ack;
    dec.scl_level  = item_i.scl_level;
    dec.sda_level  = item_i.sda_level;
    unique case (item_i.cmd)
      CMD_START: dec.kind = KIND_START;
      CMD_STOP:  dec.kind = KIND_STOP;
      CMD_WRITE: dec.kind = KIND_WRITE;
      CMD_READ:  dec.kind = KIND_READ;
      default:   dec.kind = KIND_NONE;
    endcase
  end

  i2cm_fifo #(
    .Width ($bits(fe_item_t)),
    .Depth (QUEUE_DEPTH)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (push_i),
    .wr_data_i  (dec),
    .full_o     (full_o),
    .rd_ready_i (pop_i),
    .rd_data_o  (rd_bits),
    .empty_o    (empty_o)
  );

  assign item_o = fe_item_t'(rd_bits);

endmodule

// File: src/i2cm_engine.sv
module i2cm_engine
  import i2cm_pkg::*;
#(
  parameter int WaitWidth = WAIT_WIDTH_DEFAULT
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [15:0] cfg_data_i,
  input  logic        item_valid_i,
  input  fe_item_t    item_i,
  output logic        item_take_o,
  input  logic        res_room_i,
  output logic        res_push_o,
  output res_item_t   res_o
);

  typedef enum logic [4:0] {
    PH_IDLE, PH_ST_RISE, PH_ST_W1, PH_ST_W2, PH_ST_W3, PH_ST_W4,
    PH_SP_W1, PH_SP_RISE, PH_SP_W2, PH_SP_W3,
    PH_WB_LOW, PH_WB_SETUP, PH_WB_RISE, PH_WB_HOLD,
    PH_RB_LOW, PH_RB_RISE, PH_RB_H1, PH_RB_H2, PH_RB_H3
  } phase_e;

  localparam int LimW = (WaitWidth > 16) ? WaitWidth : 16;

  phase_e               phase_q, phase_d;
  logic [3:0]           bit_count_q, bit_count_d;
  logic [7:0]           shift_q, shift_d;
  logic [WaitWidth-1:0] wait_q, wait_d;
  logic                 scl_q, scl_d;
  logic                 sda_q, sda_d;
  logic                 ack_flag_q, ack_flag_d;
  logic                 ack_to_send_q, ack_to_send_d;
  logic [7:0]           kept_read_q, kept_read_d;
  logic                 read_mode_q, read_mode_d;
  logic [15:0]          half_period_q;

  logic                 step, done;
  logic [LimW-1:0]      hp_ext, cap_ext, lim_ext;
  logic [WaitWidth-1:0] lim, wait_inc;
  logic                 tmo;
  logic [3:0]           bc_inc;
  logic                 eb_last, eb_write;

  assign cfg_ready_o = 1'b1;
  assign step        = item_valid_i && res_room_i;
  assign item_take_o = step;
  assign res_push_o  = step;

  // Wait limit: zero counts as one tick, and the count saturates at the counter's top.
  always_comb begin
    hp_ext  = LimW'(half_period_q);
    cap_ext = LimW'({WaitWidth{1'b1}});
    lim_ext = (hp_ext == '0) ? LimW'(1) : hp_ext;
    if (lim_ext > cap_ext) begin
      lim_ext = cap_ext;
    end
    lim = lim_ext[WaitWidth-1:0];
  end

  assign wait_inc = (wait_q < lim) ? wait_q + 1'b1 : wait_q;
  assign tmo      = (wait_inc >= lim);

  // Look-ahead for the end of a bit: next bit index and its direction.
  assign bc_inc   = bit_count_q + 4'd1;
  assign eb_last  = (bc_inc >= BIT_LAST);
  assign eb_write = read_mode_q ? (bc_inc >= BIT_ACK) : (bc_inc < BIT_ACK);

  // Bit sequencer: one tick of the line protocol per accepted item.
  always_comb begin
    phase_d       = phase_q;
    bit_count_d   = bit_count_q;
    shift_d       = shift_q;
    wait_d        = wait_q;
    scl_d         = scl_q;
    sda_d         = sda_q;
    ack_flag_d    = ack_flag_q;
    ack_to_send_d = ack_to_send_q;
    kept_read_d   = kept_read_q;
    read_mode_d   = read_mode_q;
    done          = 1'b0;

    unique case (phase_q)
      PH_IDLE: begin
        unique case (item_i.kind)
          KIND_START: begin
            scl_d   = 1'b0;
            phase_d = PH_ST_RISE;
            wait_d  = '0;
          end
          KIND_STOP: begin
            scl_d   = 1'b1;
            sda_d   = 1'b1;
            phase_d = PH_SP_W1;
            wait_d  = '0;
          end
          KIND_WRITE: begin
            read_mode_d   = 1'b0;
            shift_d       = item_i.write_data;
            ack_to_send_d = item_i.send_ack;
            bit_count_d   = '0;
            scl_d         = 1'b1;
            phase_d       = PH_WB_LOW;
            wait_d        = '0;
          end
          KIND_READ: begin
            read_mode_d   = 1'b1;
            shift_d       = '0;
            ack_to_send_d = item_i.send_ack;
            bit_count_d   = '0;
            scl_d         = 1'b1;
            sda_d         = 1'b0;
            phase_d       = PH_RB_LOW;
            wait_d        = '0;
          end
          default: ;
        endcase
      end
      PH_ST_RISE, PH_SP_RISE, PH_WB_RISE, PH_RB_RISE: begin
        // Released SCL: hold here while a slave stretches the clock.
        if (item_i.scl_level) begin
          wait_d = '0;
          unique case (phase_q)
            PH_ST_RISE: phase_d = PH_ST_W1;
            PH_SP_RISE: phase_d = PH_SP_W2;
            PH_WB_RISE: phase_d = PH_WB_HOLD;
            default:    phase_d = PH_RB_H1;
          endcase
        end
      end
      PH_ST_W1: begin
        wait_d = wait_inc;
        if (tmo) begin
          sda_d = 1'b0; phase_d = PH_ST_W2; wait_d = '0;
        end
      end
      PH_ST_W2: begin
        wait_d = wait_inc;
        if (tmo) begin
          sda_d = 1'b1; phase_d = PH_ST_W3; wait_d = '0;
        end
      end
      PH_ST_W3: begin
        wait_d = wait_inc;
        if (tmo) begin
          scl_d = 1'b1; phase_d = PH_ST_W4; wait_d = '0;
        end
      end
      PH_ST_W4, PH_SP_W3: begin
        wait_d = wait_inc;
        if (tmo) begin
          phase_d = PH_IDLE; wait_d = '0; done = 1'b1;
        end
      end
      PH_SP_W1: begin
        wait_d = wait_inc;
        if (tmo) begin
          scl_d = 1'b0; phase_d = PH_SP_RISE; wait_d = '0;
        end
      end
      PH_SP_W2: begin
        wait_d = wait_inc;
        if (tmo) begin
          sda_d = 1'b0; phase_d = PH_SP_W3; wait_d = '0;
        end
      end
      PH_WB_LOW: begin
        wait_d = wait_inc;
        if (tmo) begin
          // Data bits go out MSB first; the ACK bit drives low for ACK.
          if (bit_count_q < BIT_ACK) begin
            sda_d = !shift_q[3'd7 - bit_count_q[2:0]];
          end else begin
            sda_d = ack_to_send_q;
          end
          phase_d = PH_WB_SETUP;
          wait_d  = '0;
        end
      end
      PH_WB_SETUP, PH_RB_LOW: begin
        wait_d = wait_inc;
        if (tmo) begin
          scl_d   = 1'b0;
          phase_d = (phase_q == PH_WB_SETUP) ? PH_WB_RISE : PH_RB_RISE;
          wait_d  = '0;
        end
      end
      PH_RB_H1: begin
        wait_d = wait_inc;
        if (tmo) begin
          phase_d = PH_RB_H2; wait_d = '0;
        end
      end
      PH_RB_H2: begin
        wait_d = wait_inc;
        if (tmo) begin
          if (read_mode_q) begin
            shift_d = {shift_q[6:0], item_i.sda_level};
          end else begin
            ack_flag_d = !item_i.sda_level;
          end
          phase_d = PH_RB_H3;
          wait_d  = '0;
        end
      end
      PH_WB_HOLD, PH_RB_H3: begin
        wait_d = wait_inc;
        if (tmo) begin
          // End of a bit with SCL driven low: finish the byte or start the next bit.
          scl_d       = 1'b1;
          bit_count_d = bc_inc;
          wait_d      = '0;
          if (eb_last) begin
            if (read_mode_q) begin
              kept_read_d = shift_q;
            end
            phase_d = PH_IDLE;
            done    = 1'b1;
          end else if (eb_write) begin
            phase_d = PH_WB_LOW;
          end else begin
            sda_d   = 1'b0;
            phase_d = PH_RB_LOW;
          end
        end
      end
      default: begin
        phase_d = PH_IDLE;
        wait_d  = '0;
      end
    endcase
  end

  // Result of this tick: the line drives and status after the update.
  always_comb begin
    res_o.scl_pull_low = scl_d;
    res_o.sda_pull_low = sda_d;
    res_o.busy_res     = (phase_d != PH_IDLE);
    res_o.done_res     = done;
    res_o.read_data    = kept_read_d;
    res_o.ack_received = ack_flag_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q       <= PH_IDLE;
      bit_count_q   <= '0;
      shift_q       <= '0;
      wait_q        <= '0;
      scl_q         <= 1'b0;
      sda_q         <= 1'b0;
      ack_flag_q    <= 1'b0;
      ack_to_send_q <= 1'b0;
      kept_read_q   <= '0;
      read_mode_q   <= 1'b0;
      half_period_q <= HALF_PERIOD_RESET;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        half_period_q <= cfg_data_i;
      end
      if (step) begin
        phase_q       <= phase_d;
        bit_count_q   <= bit_count_d;
        shift_q       <= shift_d;
        wait_q        <= wait_d;
        scl_q         <= scl_d;
        sda_q         <= sda_d;
        ack_flag_q    <= ack_flag_d;
        ack_to_send_q <= ack_to_send_d;
        kept_read_q   <= kept_read_d;
        read_mode_q   <= read_mode_d;
      end
    end
  end

  // The bit index never runs past the ACK bit's successor.
  a_bit_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bit_count_q <= BIT_LAST)
    else $error("bit counter out of range");

  // Without an accepted item the sequencer does not move.
  a_hold_when_stalled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !step |=> $stable(phase_q) && $stable(wait_q) && $stable(scl_q) && $stable(sda_q))
    else $error("engine state changed without an item");

  // A START taken in idle releases SCL and waits for it to rise.
  a_start_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step && phase_q == PH_IDLE && item_i.kind == KIND_START
    |=> phase_q == PH_ST_RISE && !scl_q)
    else $error("START not entered correctly");

endmodule

// File: src/i2c_master_byte_engine_top.sv
// I2C master byte engine.
// Input queue: one item per clock tick of the line protocol, pushed with push while
// full is low. An item carries a command (start, stop, write byte, read byte or none)
// and the sampled SCL and SDA pin levels. Commands that arrive while busy are ignored.
// Result queue: one result per input item, in order, read while empty is low and
// taken with pop. A result gives the SCL/SDA drive-low enables, busy, a done pulse,
// the last read byte and the last received ACK.
// Configuration: one write channel (cfg_valid_i/cfg_ready_o/cfg_data_i) sets the
// half period in ticks; write it only while the engine is idle.
// An accepted item is registered in the input queue; the engine takes it from there and
// its result is registered in the result queue, which drives the result ports. Throughput:
// one item per cycle while the result queue has room.
// Reset clears both queues, releases both lines and sets the half period to 500.
// When the result side stalls, the engine holds and the input queue fills; full
// rises once the input queue holds two items and no result is lost.
module i2c_master_byte_engine_top
  import i2cm_pkg::*;
#(
  parameter int WAIT_WIDTH = WAIT_WIDTH_DEFAULT
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  in_item_t    item_i,
  output logic        empty,
  input  logic        pop,
  output res_item_t   result_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [15:0] cfg_data_i
);

  fe_item_t                     fe_item;
  logic                         fe_empty, fe_take;
  logic                         res_full, res_push;
  res_item_t                    res_item;
  logic [$bits(res_item_t)-1:0] res_bits;

  // Front end: decode and queue incoming ticks.
  i2cm_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (item_i),
    .full_o  (full),
    .pop_i   (fe_take),
    .item_o  (fe_item),
    .empty_o (fe_empty)
  );

  // Back end: the line sequencer.
  i2cm_engine #(
    .WaitWidth (WAIT_WIDTH)
  ) u_engine (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_data_i   (cfg_data_i),
    .item_valid_i (!fe_empty),
    .item_i       (fe_item),
    .item_take_o  (fe_take),
    .res_room_i   (!res_full),
    .res_push_o   (res_push),
    .res_o        (res_item)
  );

  // Result queue toward the consumer.
  i2cm_fifo #(
    .Width ($bits(res_item_t)),
    .Depth (QUEUE_DEPTH)
  ) u_res_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (res_push),
    .wr_data_i  (res_item),
    .full_o     (res_full),
    .rd_ready_i (pop),
    .rd_data_o  (res_bits),
    .empty_o    (empty)
  );

  assign result_o = res_item_t'(res_bits);

endmodule

// File: tb/tb_i2c_master_byte_engine_top.sv
module tb_i2c_master_byte_engine_top;
  import i2cm_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam time         CLK_PERIOD   = 8ns;
  localparam int unsigned RESET_CYCLES = 6;
  localparam int unsigned STUCK_LIMIT  = 4000;
  localparam int unsigned SETTLE_TICKS = 4;
  localparam int unsigned END_TICKS    = 8;
  localparam int unsigned TILL_IDLE    = 0;

  // Short half period for the bulk of the directed script.
  localparam logic [15:0] DIRECTED_HALF = 16'd1;

  // Command codes the engine does not know; they must be ignored.
  localparam logic [2:0] CMD_RSVD_LO = 3'd5;
  localparam logic [2:0] CMD_RSVD_HI = 3'd7;

  // Results that can be read straight off the protocol.
  localparam res_item_t RES_AT_REST = '0;
  localparam res_item_t RES_START_TAKEN = '{scl_pull_low: 1'b0, sda_pull_low: 1'b0,
                                            busy_res: 1'b1, done_res: 1'b0,
                                            read_data: 8'h00, ack_received: 1'b0};

  // Bus sequencer phases, one per timed or waiting step of the line protocol.
  typedef enum logic [4:0] {
    PH_IDLE,
    PH_START_RISE,
    PH_START_REL_SDA,
    PH_START_DRV_SDA,
    PH_START_DRV_SCL,
    PH_START_END,
    PH_STOP_LOW,
    PH_STOP_RISE,
    PH_STOP_REL_SDA,
    PH_STOP_END,
    PH_WR_LOW,
    PH_WR_SETUP,
    PH_WR_RISE,
    PH_WR_HOLD,
    PH_RD_LOW,
    PH_RD_RISE,
    PH_RD_HIGH,
    PH_RD_SAMPLE,
    PH_RD_TAIL
  } bus_phase_e;

  typedef enum logic [1:0] {
    RX_STREAM,
    RX_THREE_OF_FOUR,
    RX_COIN,
    RX_LONG_STALLS
  } rx_mode_e;

  typedef struct {
    in_item_t    it;
    int unsigned hold;
    bit          typed;
    res_item_t   want;
    bit          retime;
    logic [15:0] half;
  } script_row_t;

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        push        = 1'b0;
  logic        full;
  in_item_t    item_i      = '0;
  logic        empty;
  logic        pop         = 1'b0;
  res_item_t   result_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [15:0] cfg_data_i  = '0;

  // Local copy of the engine state, advanced once per accepted tick.
  bus_phase_e  eng_phase;
  logic [3:0]  bit_idx;
  logic [7:0]  shift_reg;
  logic [15:0] tick_cnt;
  logic [15:0] half_period;
  logic        scl_drv;
  logic        sda_drv;
  logic        ack_seen;
  logic        ack_out;
  logic [7:0]  last_read;
  logic        read_op;

  res_item_t   expected_results[$];
  script_row_t directed_rows[$];
  int unsigned mismatches   = 0;
  int unsigned results_seen = 0;
  int unsigned burst_left   = 0;
  int unsigned stuck_cycles = 0;
  rx_mode_e    rx_mode      = RX_STREAM;
  int unsigned rx_left      = 0;
  int unsigned rx_hold      = 0;
  logic [1:0]  rx_phase     = '0;

  i2c_master_byte_engine_top dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .item_i      (item_i),
    .empty       (empty),
    .pop         (pop),
    .result_o    (result_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // Engine predictor
  // ---------------------------------------------------------------------------

  function automatic void engine_reset();
    eng_phase   = PH_IDLE;
    bit_idx     = '0;
    shift_reg   = '0;
    tick_cnt    = '0;
    half_period = HALF_PERIOD_RESET;
    scl_drv     = 1'b0;
    sda_drv     = 1'b0;
    ack_seen    = 1'b0;
    ack_out     = 1'b0;
    last_read   = '0;
    read_op     = 1'b0;
  endfunction

  function automatic void enter(input bus_phase_e next);
    eng_phase = next;
    tick_cnt  = '0;
  endfunction

  // Counts one tick of a timed phase; a zero half period behaves as one tick.
  function automatic logic half_done();
    logic [15:0] lim;
    lim = (half_period == 16'd0) ? 16'd1 : half_period;
    if (tick_cnt < lim) tick_cnt = tick_cnt + 16'd1;
    return tick_cnt >= lim;
  endfunction

  // Data bits go out on a write and come in on a read; the ACK bit goes the other way.
  function automatic void start_bit();
    logic drive_bit;
    drive_bit = read_op ? (bit_idx >= BIT_ACK) : (bit_idx < BIT_ACK);
    scl_drv = 1'b1;
    if (drive_bit) begin
      enter(PH_WR_LOW);
    end else begin
      sda_drv = 1'b0;
      enter(PH_RD_LOW);
    end
  endfunction

  function automatic logic finish_bit();
    bit_idx = bit_idx + 4'd1;
    if (bit_idx >= BIT_LAST) begin
      if (read_op) last_read = shift_reg;
      enter(PH_IDLE);
      return 1'b1;
    end
    start_bit();
    return 1'b0;
  endfunction

  function automatic res_item_t engine_tick(input in_item_t it);
    res_item_t r;
    logic      fin;
    logic      bitv;
    fin = 1'b0;
    case (eng_phase)
      PH_IDLE: begin
        case (it.cmd)
          CMD_START: begin
            scl_drv = 1'b0;
            enter(PH_START_RISE);
          end
          CMD_STOP: begin
            scl_drv = 1'b1;
            sda_drv = 1'b1;
            enter(PH_STOP_LOW);
          end
          CMD_WRITE, CMD_READ: begin
            read_op   = (it.cmd == CMD_READ);
            shift_reg = read_op ? 8'h00 : it.write_data;
            ack_out   = it.send_ack;
            bit_idx   = '0;
            start_bit();
          end
          default: ;
        endcase
      end
      PH_START_RISE: if (it.scl_level) enter(PH_START_REL_SDA);
      PH_START_REL_SDA: if (half_done()) begin
        sda_drv = 1'b0;
        enter(PH_START_DRV_SDA);
      end
      PH_START_DRV_SDA: if (half_done()) begin
        sda_drv = 1'b1;
        enter(PH_START_DRV_SCL);
      end
      PH_START_DRV_SCL: if (half_done()) begin
        scl_drv = 1'b1;
        enter(PH_START_END);
      end
      PH_START_END: if (half_done()) begin
        enter(PH_IDLE);
        fin = 1'b1;
      end
      PH_STOP_LOW: if (half_done()) begin
        scl_drv = 1'b0;
        enter(PH_STOP_RISE);
      end
      PH_STOP_RISE: if (it.scl_level) enter(PH_STOP_REL_SDA);
      PH_STOP_REL_SDA: if (half_done()) begin
        sda_drv = 1'b0;
        enter(PH_STOP_END);
      end
      PH_STOP_END: if (half_done()) begin
        enter(PH_IDLE);
        fin = 1'b1;
      end
      PH_WR_LOW: if (half_done()) begin
        bitv    = (bit_idx < BIT_ACK) ? shift_reg[7 - bit_idx] : !ack_out;
        sda_drv = !bitv;
        enter(PH_WR_SETUP);
      end
      PH_WR_SETUP: if (half_done()) begin
        scl_drv = 1'b0;
        enter(PH_WR_RISE);
      end
      PH_WR_RISE: if (it.scl_level) enter(PH_WR_HOLD);
      PH_WR_HOLD: if (half_done()) begin
        scl_drv = 1'b1;
        fin     = finish_bit();
      end
      PH_RD_LOW: if (half_done()) begin
        scl_drv = 1'b0;
        enter(PH_RD_RISE);
      end
      PH_RD_RISE: if (it.scl_level) enter(PH_RD_HIGH);
      PH_RD_HIGH: if (half_done()) enter(PH_RD_SAMPLE);
      PH_RD_SAMPLE: if (half_done()) begin
        if (read_op) shift_reg = {shift_reg[6:0], it.sda_level};
        else         ack_seen  = !it.sda_level;
        enter(PH_RD_TAIL);
      end
      PH_RD_TAIL: if (half_done()) begin
        scl_drv = 1'b1;
        fin     = finish_bit();
      end
      default: enter(PH_IDLE);
    endcase
    r.scl_pull_low = scl_drv;
    r.sda_pull_low = sda_drv;
    r.busy_res     = (eng_phase != PH_IDLE);
    r.done_res     = fin;
    r.read_data    = last_read;
    r.ack_received = ack_seen;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------

  function automatic script_row_t row(input logic [2:0] cmd, input logic [7:0] data,
                                      input logic ack, input logic scl, input logic sda,
                                      input int unsigned hold, input bit typed = 1'b0,
                                      input res_item_t want = '0);
    script_row_t r;
    r.it.cmd        = cmd;
    r.it.write_data = data;
    r.it.send_ack   = ack;
    r.it.scl_level  = scl;
    r.it.sda_level  = sda;
    r.hold          = hold;
    r.typed         = typed;
    r.want          = want;
    r.retime        = 1'b0;
    r.half          = '0;
    return r;
  endfunction

  // A row that lets the bus drain and then writes a new half period.
  function automatic script_row_t retime_row(input logic [15:0] value);
    script_row_t r;
    r        = row(CMD_NONE, 8'h00, 1'b0, 1'b1, 1'b1, 1);
    r.retime = 1'b1;
    r.half   = value;
    return r;
  endfunction

  // Sends one tick in bursts with random gaps and records what it should produce.
  task automatic send_tick(input in_item_t it, input bit typed, input res_item_t want);
    res_item_t predicted;
    if (burst_left == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 200)
                                               : $urandom_range(1, 16);
    end
    burst_left--;
    push   <= 1'b1;
    item_i <= it;
    do @(posedge clk_i); while (full);
    predicted = engine_tick(it);
    expected_results.push_back(typed ? want : predicted);
  endtask

  // Mostly well-formed commands while idle; occasional noise while busy.
  function automatic in_item_t random_tick();
    in_item_t    it;
    int unsigned pick;
    it.write_data = 8'($urandom_range(0, 255));
    it.send_ack   = 1'($urandom_range(0, 1));
    it.sda_level  = 1'($urandom_range(0, 1));
    it.scl_level  = ($urandom_range(0, 99) < 85);
    if (eng_phase == PH_IDLE) begin
      pick = $urandom_range(0, 99);
      if      (pick < 6)  it.cmd = CMD_NONE;
      else if (pick < 10) it.cmd = 3'($urandom_range(CMD_RSVD_LO, CMD_RSVD_HI));
      else if (pick < 30) it.cmd = CMD_START;
      else if (pick < 50) it.cmd = CMD_STOP;
      else if (pick < 75) it.cmd = CMD_WRITE;
      else                it.cmd = CMD_READ;
    end else begin
      it.cmd = ($urandom_range(0, 9) == 0) ? 3'($urandom) : CMD_NONE;
    end
    return it;
  endfunction

  task automatic run_random(input int unsigned ticks, input bit finish_cmd);
    in_item_t it;
    repeat (ticks) send_tick(random_tick(), 1'b0, '0);
    // Let the bus run out the current command with SCL released.
    while (finish_cmd && eng_phase != PH_IDLE) begin
      it           = random_tick();
      it.cmd       = CMD_NONE;
      it.scl_level = 1'b1;
      send_tick(it, 1'b0, '0);
    end
  endtask

  // Stops sending and waits for every outstanding transaction to come back.
  task automatic drain();
    push <= 1'b0;
    burst_left = 0;
    while (expected_results.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_half_period(input logic [15:0] value);
    repeat (SETTLE_TICKS) @(posedge clk_i);
    cfg_data_i  <= value;
    cfg_valid_i <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    half_period = value;
  endtask

  initial begin
    script_row_t r;
    engine_reset();

    // Directed script: the first rows run at the reset half period, the rest at a short one.
    directed_rows.push_back(row(CMD_NONE,   8'h00, 1'b0, 1'b1, 1'b1, 1, 1'b1, RES_AT_REST));
    directed_rows.push_back(row(CMD_RSVD_LO, 8'h00, 1'b0, 1'b1, 1'b1, 1, 1'b1, RES_AT_REST));
    directed_rows.push_back(row(CMD_RSVD_LO + 3'd1, 8'h5A, 1'b1, 1'b0, 1'b0, 1, 1'b1,
                                RES_AT_REST));
    directed_rows.push_back(row(CMD_RSVD_HI, 8'hFF, 1'b1, 1'b1, 1'b1, 1, 1'b1, RES_AT_REST));
    directed_rows.push_back(row(CMD_START,  8'h00, 1'b0, 1'b0, 1'b1, 1, 1'b1,
                                RES_START_TAKEN));
    // Slave stretches SCL; a write arriving meanwhile is dropped.
    directed_rows.push_back(row(CMD_NONE,   8'h00, 1'b0, 1'b0, 1'b1, 20));
    directed_rows.push_back(row(CMD_WRITE,  8'hFF, 1'b1, 1'b0, 1'b1, 1));
    // Part of the first half period at the reset value, then a shorter one mid-wait.
    directed_rows.push_back(row(CMD_NONE,   8'h00, 1'b0, 1'b1, 1'b1, 40));
    directed_rows.push_back(retime_row(DIRECTED_HALF));
    directed_rows.push_back(row(CMD_NONE,   8'h00, 1'b0, 1'b1, 1'b1, TILL_IDLE));
    // Write all zeros with the slave acknowledging, then all ones with a NACK.
    directed_rows.push_back(row(CMD_WRITE,  8'h00, 1'b0, 1'b1, 1'b0, 1));
    directed_rows.push_back(row(CMD_NONE,   8'h00, 1'b0, 1'b1, 1'b0, TILL_IDLE));
    directed_rows.push_back(row(CMD_WRITE,  8'hFF, 1'b1, 1'b1, 1'b1, 1));
    directed_rows.push_back(row(CMD_NONE,   8'h00, 1'b0, 1'b1, 1'b1, TILL_IDLE));
    // Read all ones and send ACK, then read all zeros and send NACK.
    directed_rows.push_back(row(CMD_READ,   8'h00, 1'b1, 1'b1, 1'b1, 1));
    directed_rows.push_back(row(CMD_NONE,   8'hFF, 1'b1, 1'b1, 1'b1, TILL_IDLE));
    directed_rows.push_back(row(CMD_READ,   8'hFF, 1'b0, 1'b1, 1'b0, 1));
    directed_rows.push_back(row(CMD_NONE,   8'h00, 1'b0, 1'b1, 1'b0, TILL_IDLE));
    directed_rows.push_back(row(CMD_STOP,   8'h00, 1'b0, 1'b1, 1'b1, 1));
    directed_rows.push_back(row(CMD_STOP,   8'h00, 1'b0, 1'b1, 1'b1, 1));
    directed_rows.push_back(row(CMD_NONE,   8'h00, 1'b0, 1'b1, 1'b1, TILL_IDLE));
    directed_rows.push_back(row(CMD_NONE,   8'h00, 1'b0, 1'b1, 1'b1, 1));

    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (directed_rows[i]) begin
      r = directed_rows[i];
      if (r.retime) begin
        drain();
        write_half_period(r.half);
      end else if (r.hold == TILL_IDLE) begin
        do send_tick(r.it, 1'b0, '0); while (eng_phase != PH_IDLE);
      end else begin
        repeat (r.hold) send_tick(r.it, r.typed, r.want);
      end
    end
    drain();

    // Random traffic over several half periods, the extremes among them.
    write_half_period(16'd0);
    run_random(120, 1'b1);
    drain();
    write_half_period(16'd1);
    run_random(120, 1'b1);
    drain();
    write_half_period(16'($urandom_range(2, 6)));
    run_random(100, 1'b1);
    drain();
    write_half_period(16'hFFFF);
    run_random(40, 1'b0);
    drain();

    repeat (END_TICKS) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("tb_i2c_master_byte_engine_top OK");
    end else begin
      $display("tb_i2c_master_byte_engine_top NOT OK");
    end
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Result side: stall pattern and checking
  // ---------------------------------------------------------------------------

  task automatic report(input string what);
    $display("result %0d: %s", results_seen, what);
    mismatches++;
  endtask

  task automatic check_result(input res_item_t got, input res_item_t want);
    if (got.scl_pull_low !== want.scl_pull_low)
      report($sformatf("scl_pull_low %0b, expected %0b", got.scl_pull_low, want.scl_pull_low));
    if (got.sda_pull_low !== want.sda_pull_low)
      report($sformatf("sda_pull_low %0b, expected %0b", got.sda_pull_low, want.sda_pull_low));
    if (got.busy_res !== want.busy_res)
      report($sformatf("busy_res %0b, expected %0b", got.busy_res, want.busy_res));
    if (got.done_res !== want.done_res)
      report($sformatf("done_res %0b, expected %0b", got.done_res, want.done_res));
    if (got.read_data !== want.read_data)
      report($sformatf("read_data %02h, expected %02h", got.read_data, want.read_data));
    if (got.ack_received !== want.ack_received)
      report($sformatf("ack_received %0b, expected %0b", got.ack_received, want.ack_received));
  endtask

  // Each popped transaction is checked against the oldest expectation.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        if (expected_results.size() == 0) report("result with no transaction outstanding");
        else check_result(result_o, expected_results.pop_front());
        results_seen++;
      end
      // The stall pattern switches at random between four shapes.
      if (rx_left == 0) begin
        rx_mode = rx_mode_e'($urandom_range(0, 3));
        rx_left = $urandom_range(50, 300);
      end
      rx_left--;
      rx_phase = rx_phase + 2'd1;
      case (rx_mode)
        RX_STREAM:        pop <= 1'b1;
        RX_THREE_OF_FOUR: pop <= (rx_phase != 2'b11);
        RX_COIN:          pop <= 1'($urandom_range(0, 1));
        default: begin
          if (rx_hold != 0) begin
            rx_hold--;
            pop <= 1'b0;
          end else begin
            pop <= 1'b1;
            if ($urandom_range(0, 15) == 0) rx_hold = $urandom_range(1, 15);
          end
        end
      endcase
    end
  end

  // Watchdog: ends the run when no transaction moves for too long.
  always @(posedge clk_i) begin
    if ((push && !full) || (pop && !empty) || (cfg_valid_i && cfg_ready_o)) begin
      stuck_cycles = 0;
    end else begin
      stuck_cycles++;
      if (stuck_cycles >= STUCK_LIMIT) begin
        $display("tb_i2c_master_byte_engine_top NOT OK");
        $finish;
      end
    end
  end

endmodule
